// File: hw/rtl/palindrome_min_insertions_unit_defines.svh
`ifndef PALINDROME_MIN_INSERTIONS_UNIT_DEFINES_SVH
`define PALINDROME_MIN_INSERTIONS_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PMI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmi check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PMI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmi check failed");

`endif

// File: hw/rtl/pmi_pkg.sv
`timescale 1ns / 1ps

package pmi_pkg;

    localparam int MAX_LEN = 4096;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int INS_W   = 12;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [INS_W-1:0] insertions;
        logic             too_long;
    } result_t;

endpackage

// File: hw/rtl/palindrome_min_insertions_unit.sv
// Bytes are taken one per cycle while busy is low; no result follows a byte without last.
// After the byte with last, busy stays high until done strobes for a string of n
// stored bytes: one compare/min unit updates one cell of the single stored row per
// cycle, after the S_ROW and S_FETCH steps that open each row.
// The receiver cannot stall; the result is valid only in the done cycle.
// Reset (rst_n low, asynchronous) empties the string and clears the overflow flag.
`timescale 1ns / 1ps

module palindrome_min_insertions_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pmi_pkg::item_t    item,
    output logic              done,
    output pmi_pkg::result_t  result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROW,
        S_FETCH,
        S_RUN
    } state_t;

    localparam int IW = pmi_pkg::IDX_W;
    localparam int CW = pmi_pkg::CNT_W;
    localparam int NW = pmi_pkg::INS_W;

    state_t             state_reg, state_next;
    logic [CW-1:0]      len_reg, len_next;
    logic               ovf_reg, ovf_next;
    logic [IW-1:0]      last_idx_reg, last_idx_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [IW-1:0]      j_reg, j_next;
    logic [7:0]         ti_reg, ti_next;
    logic [NW-1:0]      left_reg, left_next;
    logic [NW-1:0]      diag_reg, diag_next;
    logic               done_reg, done_next;
    pmi_pkg::result_t   result_reg, result_next;

    // Text store: written while loading, read one address per cycle while computing.
    logic [7:0]         text_mem [pmi_pkg::MAX_LEN];
    logic               text_we;
    logic [IW-1:0]      text_waddr;
    logic [IW-1:0]      text_raddr;
    logic [7:0]         text_rdata;

    // Row store: one write and one read per cycle, at different addresses.
    logic [NW-1:0]      dp_mem [pmi_pkg::MAX_LEN];
    logic               dp_we;
    logic [IW-1:0]      dp_waddr;
    logic [NW-1:0]      dp_wdata;
    logic [IW-1:0]      dp_raddr;
    logic [NW-1:0]      dp_rdata;

    logic               accept;
    logic               room;
    logic [NW-1:0]      min_val;
    logic [NW:0]        sum_val;
    logic [NW-1:0]      cell_val;

    always_ff @(posedge clk)
    begin
        if (text_we)
        begin
            text_mem[text_waddr] <= item.char_code;
        end
        text_rdata <= text_mem[text_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dp_we)
        begin
            dp_mem[dp_waddr] <= dp_wdata;
        end
        dp_rdata <= dp_mem[dp_raddr];
    end

    assign accept = start && (state_reg == S_IDLE);
    assign room   = (len_reg < CW'(pmi_pkg::MAX_LEN));

    // The shared cell unit: equal ends take the inner value, else one plus the smaller.
    assign min_val  = (dp_rdata < left_reg) ? dp_rdata : left_reg;
    assign sum_val  = {1'b0, min_val} + {{NW{1'b0}}, 1'b1};
    assign cell_val = (ti_reg == text_rdata) ? diag_reg
                    : (sum_val[NW] ? {NW{1'b1}} : sum_val[NW-1:0]);

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        last_idx_next = last_idx_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        ti_next       = ti_reg;
        left_next     = left_reg;
        diag_next     = diag_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        text_we    = 1'b0;
        text_waddr = len_reg[IW-1:0];
        text_raddr = i_reg;
        dp_we      = 1'b0;
        dp_waddr   = i_reg;
        dp_wdata   = '0;
        dp_raddr   = j_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        text_we  = 1'b1;
                        len_next = len_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        last_idx_next = room ? len_reg[IW-1:0] : IW'(pmi_pkg::MAX_LEN - 1);
                        i_next        = room ? len_reg[IW-1:0] : IW'(pmi_pkg::MAX_LEN - 1);
                        state_next    = S_ROW;
                    end
                end
            end

            S_ROW:
            begin
                // Open row i: the diagonal cell is zero, and fetch the left end byte.
                text_raddr = i_reg;
                dp_we      = 1'b1;
                dp_waddr   = i_reg;
                dp_wdata   = '0;
                left_next  = '0;
                diag_next  = '0;
                state_next = S_FETCH;
            end

            S_FETCH:
            begin
                ti_next = text_rdata;
                if (i_reg == last_idx_reg)
                begin
                    if (i_reg == '0)
                    begin
                        done_next              = 1'b1;
                        result_next.insertions = '0;
                        result_next.too_long   = ovf_reg;
                        len_next               = '0;
                        ovf_next               = 1'b0;
                        state_next             = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg - IW'(1);
                        state_next = S_ROW;
                    end
                end
                else
                begin
                    text_raddr = i_reg + IW'(1);
                    dp_raddr   = i_reg + IW'(1);
                    j_next     = i_reg + IW'(1);
                    state_next = S_RUN;
                end
            end

            S_RUN:
            begin
                dp_we      = 1'b1;
                dp_waddr   = j_reg;
                dp_wdata   = cell_val;
                left_next  = cell_val;
                diag_next  = dp_rdata;
                text_raddr = j_reg + IW'(1);
                dp_raddr   = j_reg + IW'(1);
                j_next     = j_reg + IW'(1);
                if (j_reg == last_idx_reg)
                begin
                    if (i_reg == '0)
                    begin
                        done_next              = 1'b1;
                        result_next.insertions = cell_val;
                        result_next.too_long   = ovf_reg;
                        len_next               = '0;
                        ovf_next               = 1'b0;
                        state_next             = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg - IW'(1);
                        state_next = S_ROW;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_idx_reg <= last_idx_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        ti_reg       <= ti_next;
        left_reg     <= left_next;
        diag_reg     <= diag_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: hw/rtl/pmi_checker.sv
`timescale 1ns / 1ps
`include "palindrome_min_insertions_unit_defines.svh"

module pmi_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input pmi_pkg::item_t    item,
    input logic              done
);

    // A result is only shown once the computation has ended.
    `PMI_ASSERT_SAME(a_done_idle, done, !busy)

    // Each result is a single-cycle strobe.
    `PMI_ASSERT_NEXT(a_done_pulse, done, !done)

    // A byte that does not end the string never starts a computation or a result.
    `PMI_ASSERT_NEXT(a_byte_no_result, start && !busy && !item.last, !busy && !done)

    // The final byte always starts a computation.
    `PMI_ASSERT_NEXT(a_last_starts, start && !busy && item.last, busy && !done)

endmodule

bind palindrome_min_insertions_unit pmi_checker u_pmi_checker (.*);
